@@ rtl/mcp_pkg.sv @@
package mcp_pkg;

  localparam int NUM_COLORS  = 256;
  localparam int SAMPLE_BITS = 16;

  localparam int IDX_W   = $clog2(NUM_COLORS);
  localparam int SUM_W   = 2 * SAMPLE_BITS;
  localparam int ROOT_W  = SAMPLE_BITS;
  localparam int REG_W   = 17;
  localparam int MAG_W   = ROOT_W + 1;
  localparam int DIFF_W  = ((MAG_W > REG_W) ? MAG_W : REG_W) + 1;
  localparam int NUMS_W  = DIFF_W + IDX_W + 2;
  localparam int D_W     = REG_W + 2;
  localparam int CFG_A_W = 2;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_COMPLEX_MODE  = 2'd0,
    CFG_COLOR_MIN     = 2'd1,
    CFG_COLOR_MAX     = 2'd2,
    CFG_COLORMAP_TYPE = 2'd3
  } cfg_idx_t;

  // classification of the quantizer numerator
  typedef struct packed {
    logic err;
    logic neg;
    logic top;
  } mcp_flags_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  function automatic logic [7:0] sat8(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return 8'(v);
  endfunction

  function automatic rgb_t lookup(input logic [IDX_W-1:0] idx, input logic grey);
    int   i;
    int   rv;
    int   gv;
    int   bv;
    rgb_t c;
    i  = int'({1'b0, idx});
    rv = 0;
    gv = 0;
    bv = 0;
    if (i == 0) begin
      rv = 0; gv = 0; bv = 0;
    end else if (grey) begin
      rv = (i * 256) / NUM_COLORS; gv = rv; bv = rv;
    end else if (i < NUM_COLORS / 4) begin
      rv = 0; gv = (i * 1024) / NUM_COLORS; bv = 255;
    end else if (i < NUM_COLORS / 2) begin
      rv = 0; gv = 255; bv = ((NUM_COLORS - 2 * i) * 512) / NUM_COLORS;
    end else if (i < (3 * NUM_COLORS) / 4) begin
      rv = ((2 * i - NUM_COLORS) < 0) ? -1 : ((2 * i - NUM_COLORS) * 512) / NUM_COLORS;
      gv = 255; bv = 0;
    end else begin
      rv = 255; gv = ((NUM_COLORS - i) * 1024) / NUM_COLORS; bv = 0;
    end
    c.r = sat8(rv);
    c.g = sat8(gv);
    c.b = sat8(bv);
    return c;
  endfunction

endpackage

@@ rtl/mcp_isqrt.sv @@
module mcp_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [mcp_pkg::SUM_W-1:0]  x,
  output logic                       out_valid,
  output logic [mcp_pkg::ROOT_W-1:0] root
);
  import mcp_pkg::*;

  // one result bit per stage
  logic [SUM_W-1:0] x_in   [0:ROOT_W-1];
  logic [SUM_W-1:0] res_in [0:ROOT_W-1];
  logic             v_in   [0:ROOT_W-1];
  logic [SUM_W-1:0] x_r    [0:ROOT_W-1];
  logic [SUM_W-1:0] res_r  [0:ROOT_W-1];
  logic             v_r    [0:ROOT_W-1];

  assign x_in[0]   = x;
  assign res_in[0] = '0;
  assign v_in[0]   = in_valid;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (ROOT_W - 1 - k));
    logic [SUM_W-1:0] trial;
    logic [SUM_W-1:0] x_nxt;
    logic [SUM_W-1:0] res_nxt;

    if (k > 0) begin : g_link
      assign x_in[k]   = x_r[k-1];
      assign res_in[k] = res_r[k-1];
      assign v_in[k]   = v_r[k-1];
    end

    always_comb begin
      trial = res_in[k] + BIT;
      if (x_in[k] >= trial) begin
        x_nxt   = x_in[k] - trial;
        res_nxt = (res_in[k] >> 1) + BIT;
      end else begin
        x_nxt   = x_in[k];
        res_nxt = res_in[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]   <= x_nxt;
        res_r[k] <= res_nxt;
      end
    end
  end

  assign out_valid = v_r[ROOT_W-1];
  assign root      = res_r[ROOT_W-1][ROOT_W-1:0];

endmodule

@@ rtl/mcp_qdiv.sv @@
module mcp_qdiv (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [mcp_pkg::NUMS_W-1:0] num,
  input  logic [mcp_pkg::D_W-1:0]    den,
  input  mcp_pkg::mcp_flags_t       in_flags,
  output logic                      out_valid,
  output logic [mcp_pkg::IDX_W-1:0] quo,
  output mcp_pkg::mcp_flags_t       out_flags
);
  import mcp_pkg::*;

  // restoring division, one quotient bit per stage, MSB first
  logic [NUMS_W-1:0] rem_in [0:IDX_W-1];
  logic [IDX_W-1:0]  q_in   [0:IDX_W-1];
  logic              v_in   [0:IDX_W-1];
  mcp_flags_t        f_in   [0:IDX_W-1];
  logic [D_W-1:0]    d_in   [0:IDX_W-1];
  logic [NUMS_W-1:0] rem_r  [0:IDX_W-1];
  logic [IDX_W-1:0]  q_r    [0:IDX_W-1];
  logic              v_r    [0:IDX_W-1];
  mcp_flags_t        f_r    [0:IDX_W-1];
  logic [D_W-1:0]    d_r    [0:IDX_W-1];

  assign rem_in[0] = num;
  assign q_in[0]   = '0;
  assign v_in[0]   = in_valid;
  assign f_in[0]   = in_flags;
  assign d_in[0]   = den;

  for (genvar k = 0; k < IDX_W; k++) begin : g_stage
    localparam int SH = IDX_W - 1 - k;
    logic [NUMS_W-1:0] dsh;
    logic [NUMS_W-1:0] rem_nxt;
    logic [IDX_W-1:0]  q_nxt;

    if (k > 0) begin : g_link
      assign rem_in[k] = rem_r[k-1];
      assign q_in[k]   = q_r[k-1];
      assign v_in[k]   = v_r[k-1];
      assign f_in[k]   = f_r[k-1];
      assign d_in[k]   = d_r[k-1];
    end

    always_comb begin
      dsh     = NUMS_W'(d_in[k]) << SH;
      rem_nxt = rem_in[k];
      q_nxt   = q_in[k];
      if (rem_in[k] >= dsh) begin
        rem_nxt   = rem_in[k] - dsh;
        q_nxt[SH] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        q_r[k]   <= q_nxt;
        f_r[k]   <= f_in[k];
        d_r[k]   <= d_in[k];
      end
    end
  end

  assign out_valid = v_r[IDX_W-1];
  assign quo       = q_r[IDX_W-1];
  assign out_flags = f_r[IDX_W-1];

endmodule

@@ rtl/magnitude_colormap_pixel.sv @@
// Pipeline: capture, squares, sum, square root, numerator, clamp classes, divider, output.
// Throughput: one beat per cycle; the whole pipeline advances unless the
//   output register holds a beat that is stalled.
// Reset (rst_n, synchronous): valid bits clear, registers return to
//   complex_mode=1, color_min=0, color_max=46341, colormap_type=0.
module magnitude_colormap_pixel (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mcp_pkg::CFG_A_W-1:0]         cfg_index,
  input  logic [mcp_pkg::REG_W-1:0]           cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [mcp_pkg::SAMPLE_BITS-1:0] in_real_part,
  input  logic signed [mcp_pkg::SAMPLE_BITS-1:0] in_imag_part,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          out_color_index,
  output logic [7:0]                          out_red,
  output logic [7:0]                          out_green,
  output logic [7:0]                          out_blue,
  output logic                                out_range_error
);
  import mcp_pkg::*;

  // ---------------- configuration registers ----------------
  logic                    complex_mode_r;
  logic signed [REG_W-1:0] color_min_r;
  logic signed [REG_W-1:0] color_max_r;
  logic                    colormap_type_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      complex_mode_r  <= 1'b1;
      color_min_r     <= '0;
      color_max_r     <= REG_W'(46341);
      colormap_type_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_COMPLEX_MODE:  complex_mode_r  <= cfg_wdata[0];
        CFG_COLOR_MIN:     color_min_r     <= cfg_wdata;
        CFG_COLOR_MAX:     color_max_r     <= cfg_wdata;
        CFG_COLORMAP_TYPE: colormap_type_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Global advance: pipeline moves as one unit, held only by a stalled output beat.
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // ---------------- stage 1: input capture ----------------
  logic                          v1_r;
  logic signed [SAMPLE_BITS-1:0] re1_r;
  logic signed [SAMPLE_BITS-1:0] im1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      re1_r <= in_real_part;
      im1_r <= in_imag_part;
    end
  end

  // ---------------- stage 2: squares of magnitudes ----------------
  logic [SAMPLE_BITS:0]          abs_re;
  logic [SAMPLE_BITS:0]          abs_im;
  logic [2*SAMPLE_BITS+1:0]      sq_re;
  logic [2*SAMPLE_BITS+1:0]      sq_im;
  logic                          v2_r;
  logic [SUM_W-2:0]              sqr2_r;
  logic [SUM_W-2:0]              sqi2_r;
  logic signed [SAMPLE_BITS-1:0] re2_r;

  always_comb begin
    abs_re = re1_r[SAMPLE_BITS-1] ? -{re1_r[SAMPLE_BITS-1], re1_r} : {re1_r[SAMPLE_BITS-1], re1_r};
    abs_im = im1_r[SAMPLE_BITS-1] ? -{im1_r[SAMPLE_BITS-1], im1_r} : {im1_r[SAMPLE_BITS-1], im1_r};
    sq_re  = abs_re * abs_re;
    sq_im  = abs_im * abs_im;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sqr2_r <= sq_re[SUM_W-2:0];
      sqi2_r <= sq_im[SUM_W-2:0];
      re2_r  <= re1_r;
    end
  end

  // ---------------- stage 3: sum of squares ----------------
  logic                          v3_r;
  logic [SUM_W-1:0]              sum3_r;
  logic signed [SAMPLE_BITS-1:0] re3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sum3_r <= SUM_W'(sqr2_r) + SUM_W'(sqi2_r);
      re3_r  <= re2_r;
    end
  end

  // ---------------- square root pipeline ----------------
  logic              sq_valid;
  logic [ROOT_W-1:0] root;

  mcp_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v3_r),
    .x         (sum3_r),
    .out_valid (sq_valid),
    .root      (root)
  );

  // real part rides alongside the root stages for real mode
  logic signed [SAMPLE_BITS-1:0] re_d_r [0:ROOT_W-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      re_d_r[0] <= re3_r;
      for (int k = 1; k < ROOT_W; k++) re_d_r[k] <= re_d_r[k-1];
    end
  end

  // ---------------- stage P: quantizer numerator ----------------
  logic signed [MAG_W-1:0]  mag;
  logic signed [DIFF_W-1:0] diff;
  logic signed [REG_W:0]    range;
  logic signed [NUMS_W-1:0] num;
  logic                     vp_r;
  logic signed [NUMS_W-1:0] nump_r;
  logic [D_W-1:0]           dp_r;
  logic                     errp_r;

  always_comb begin
    mag   = complex_mode_r ? $signed({1'b0, root})
                           : MAG_W'(re_d_r[ROOT_W-1]);
    diff  = DIFF_W'(mag) - DIFF_W'(color_min_r);
    range = (REG_W+1)'(color_max_r) - (REG_W+1)'(color_min_r);
    num   = NUMS_W'(diff) * NUMS_W'(2 * NUM_COLORS) + NUMS_W'(range);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vp_r <= 1'b0;
    else if (adv) vp_r <= sq_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      nump_r <= num;
      dp_r   <= D_W'({range, 1'b0});
      errp_r <= (range <= 0);
    end
  end

  // ---------------- stage Q: clamp classification ----------------
  logic [NUMS_W-1:0] top_lim;
  logic              vq_r;
  logic [NUMS_W-1:0] numq_r;
  logic [D_W-1:0]    dq_r;
  mcp_flags_t        fq_r;

  assign top_lim = NUMS_W'(dp_r) * NUMS_W'(NUM_COLORS);

  always_ff @(posedge clk) begin
    if (!rst_n) vq_r <= 1'b0;
    else if (adv) vq_r <= vp_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      numq_r   <= nump_r;
      dq_r     <= dp_r;
      fq_r.err <= errp_r;
      fq_r.neg <= nump_r[NUMS_W-1];
      fq_r.top <= !nump_r[NUMS_W-1] && (nump_r >= top_lim);
    end
  end

  // ---------------- divider pipeline ----------------
  logic             dv_valid;
  logic [IDX_W-1:0] quo;
  mcp_flags_t       dflags;

  mcp_qdiv u_qdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (vq_r),
    .num       (numq_r),
    .den       (dq_r),
    .in_flags  (fq_r),
    .out_valid (dv_valid),
    .quo       (quo),
    .out_flags (dflags)
  );

  // ---------------- output stage: clamp and color lookup ----------------
  logic [IDX_W-1:0]   idx;
  logic [IDX_W+7:0]   idx_ext;
  rgb_t               rgb;
  logic               out_valid_r;
  logic [7:0]         cidx_r;
  rgb_t               rgb_r;
  logic               err_r;

  always_comb begin
    if (dflags.err || dflags.neg) idx = '0;
    else if (dflags.top)          idx = IDX_W'(NUM_COLORS - 1);
    else                          idx = quo;
    idx_ext = {8'd0, idx};
    rgb     = lookup(idx, colormap_type_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= dv_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      cidx_r <= idx_ext[7:0];
      rgb_r  <= rgb;
      err_r  <= dflags.err;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_color_index = cidx_r;
  assign out_red         = rgb_r.r;
  assign out_green       = rgb_r.g;
  assign out_blue        = rgb_r.b;
  assign out_range_error = err_r;

  // ---------------- assertions ----------------
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled output beat");

  a_err_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_error) |->
      (out_color_index == 8'd0 && out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0))
    else $error("range error beat is not black at index zero");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_color_index) && $stable(out_red)))
    else $error("stalled output beat changed");

endmodule
